// File: hw/rtl/hgup_pkg.sv
// Shared types and constants for the GET request URI hash parser.
`timescale 1ns / 1ps
`default_nettype none

package hgup_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_E,
    PH_T,
    PH_SLASH,
    PH_UNIT,
    PH_E1H,
    PH_E1L,
    PH_SKIP,
    PH_E2H,
    PH_E2L
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOGET = 2'd1,
    ST_NOEND = 2'd2
  } status_e;

  localparam logic CFG_UNIT_LIMIT   = 1'b0;
  localparam logic CFG_DEFAULT_HASH = 1'b1;

  localparam logic [7:0] UNIT_LIMIT_RST   = 8'd60;
  localparam logic [7:0] DEFAULT_HASH_RST = 8'h0B;
  localparam logic [7:0] HASH_MULT        = 8'd37;
  localparam logic [15:0] MIN_GET_LEN     = 16'd3;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;

  localparam logic [2:0] UTF8_LEAD2 = 3'b110;

  // One classified input word as it travels from the front to the back.
  typedef struct packed {
    logic        first;
    logic        len_short;
    logic [15:0] len_m1;
    logic        is_g;
    logic        is_e;
    logic        is_t;
    logic        is_slash;
    logic        is_pct;
    logic        is_space;
    logic [7:0]  byte_val;
    logic [7:0]  nib;
  } cls_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/http_get_uri_hash_parser.sv
// Top level of the GET request URI hash parser.
// One word is taken per cycle while the queue has room; a result can be taken once the word
// that decides it has passed through the queue and then been registered in the result register.
// Sustained rate is one word per cycle whenever the output side is ready.
// Reset clears the queue, the parser state and the result valid flag, and loads the
// unit limit with 60 and the default hash with 11; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module http_get_uri_hash_parser #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte [7:0], segment_length [23:8]
  input  wire logic        s_axis_tuser,   // first_byte [0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // status [1:0], uri_hash [9:2], zero [15:10]
);
  import hgup_pkg::*;

  logic       [7:0] unit_limit_q;
  logic       [7:0] default_hash_q;
  cls_word_t        in_word;
  cls_word_t        q_word;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             in_push;
  status_e          res_status;
  logic       [7:0] res_hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_limit_q   <= UNIT_LIMIT_RST;
      default_hash_q <= DEFAULT_HASH_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_UNIT_LIMIT) begin
        unit_limit_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_DEFAULT_HASH) begin
        default_hash_q <= cfg_data_i;
      end
    end
  end

  hgup_front u_front (
    .data_byte_i      (s_axis_tdata[7:0]),
    .first_byte_i     (s_axis_tuser),
    .segment_length_i (s_axis_tdata[23:8]),
    .word_o           (in_word)
  );

  assign s_axis_tready = !q_full;
  assign in_push       = s_axis_tvalid && s_axis_tready;

  hgup_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_push),
    .word_i  (in_word),
    .full_o  (q_full),
    .valid_o (q_valid),
    .word_o  (q_word),
    .pop_i   (q_pop)
  );

  hgup_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .unit_limit_i   (unit_limit_q),
    .default_hash_i (default_hash_q),
    .word_valid_i   (q_valid),
    .word_i         (q_word),
    .pop_o          (q_pop),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_status_o   (res_status),
    .res_hash_o     (res_hash)
  );

  assign m_axis_tdata = {6'd0, res_hash, res_status};

  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_valid)
    else $error("Queue reports full while empty.");

  a_push_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_push |=> q_valid)
    else $error("Accepted word did not reach the queue.");

  a_pop_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("Back end popped an empty queue.");

  a_bad_status_zero_hash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status != ST_OK) |-> (res_hash == 8'd0))
    else $error("Error result carries a nonzero hash.");

endmodule

`default_nettype wire

// File: hw/rtl/hgup_front.sv
// Front end: classifies each received byte before it is queued.
`timescale 1ns / 1ps
`default_nettype none

module hgup_front (
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             first_byte_i,
  input  wire logic [15:0]      segment_length_i,
  output hgup_pkg::cls_word_t   word_o
);
  import hgup_pkg::*;

  logic [7:0] nib;

  always_comb begin
    if (data_byte_i >= CH_0 && data_byte_i <= CH_9) begin
      nib = data_byte_i - CH_0;
    end else if (data_byte_i >= CH_LA && data_byte_i <= CH_LF) begin
      nib = data_byte_i - CH_LA + 8'd10;
    end else begin
      nib = data_byte_i + 8'd10 - CH_UA;
    end
  end

  always_comb begin
    word_o.first     = first_byte_i;
    word_o.len_short = (segment_length_i <= MIN_GET_LEN);
    word_o.len_m1    = segment_length_i - 16'd1;
    word_o.is_g      = (data_byte_i == CH_G);
    word_o.is_e      = (data_byte_i == CH_E);
    word_o.is_t      = (data_byte_i == CH_T);
    word_o.is_slash  = (data_byte_i == CH_SLASH);
    word_o.is_pct    = (data_byte_i == CH_PCT);
    word_o.is_space  = (data_byte_i == CH_SPACE);
    word_o.byte_val  = data_byte_i;
    word_o.nib       = nib;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hgup_fifo.sv
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module hgup_fifo #(
  parameter int Depth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire hgup_pkg::cls_word_t word_i,
  output logic                     full_o,
  output logic                     valid_o,
  output hgup_pkg::cls_word_t      word_o,
  input  wire logic                pop_i
);
  import hgup_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cls_word_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hgup_back.sv
// Back end: request parser state machine, URI hash and result register.
`timescale 1ns / 1ps
`default_nettype none

module hgup_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          unit_limit_i,
  input  wire logic [7:0]          default_hash_i,
  input  wire logic                word_valid_i,
  input  wire hgup_pkg::cls_word_t word_i,
  output logic                     pop_o,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output hgup_pkg::status_e        res_status_o,
  output logic [7:0]               res_hash_o
);
  import hgup_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  units_left_q, units_left_d;
  logic [7:0]  hash_q, hash_d;
  logic [7:0]  esc_q, esc_d;
  logic [7:0]  lead_q, lead_d;
  logic        res_valid_q, res_valid_d;
  status_e     res_status_q, res_status_d;
  logic [7:0]  res_hash_q, res_hash_d;

  logic [15:0] bl;
  logic [7:0]  prod;
  logic [7:0]  unit;
  logic [7:0]  esc_full;
  logic [7:0]  units_new;
  logic        do_fold;
  logic        check_end;
  logic        emit;
  status_e     emit_status;
  logic [7:0]  emit_hash;

  assign pop_o        = word_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_hash_o   = res_hash_q;

  assign bl       = bytes_left_q - 16'd1;
  assign esc_full = esc_q | word_i.nib;
  assign prod     = hash_q * HASH_MULT;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    units_left_d = units_left_q;
    hash_d       = hash_q;
    esc_d        = esc_q;
    lead_d       = lead_q;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_hash    = 8'd0;
    do_fold      = 1'b0;
    check_end    = 1'b0;
    unit         = word_i.byte_val;
    units_new    = units_left_q - 8'd1;

    if (pop_o) begin
      if (word_i.first) begin
        if (word_i.len_short) begin
          emit        = 1'b1;
          emit_status = ST_NOGET;
        end else begin
          bytes_left_d = word_i.len_m1;
          hash_d       = 8'd0;
          esc_d        = 8'd0;
          lead_d       = 8'd0;
          units_left_d = 8'd0;
          if (!word_i.is_g) begin
            emit        = 1'b1;
            emit_status = ST_NOGET;
          end else begin
            phase_d = PH_E;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        bytes_left_d = bl;
        case (phase_q)
          PH_E: begin
            if (!word_i.is_e) begin
              emit        = 1'b1;
              emit_status = ST_NOGET;
            end else begin
              phase_d = PH_T;
            end
          end
          PH_T: begin
            if (!word_i.is_t) begin
              emit        = 1'b1;
              emit_status = ST_NOGET;
            end else begin
              phase_d = PH_SLASH;
            end
          end
          PH_SLASH: begin
            if (word_i.is_slash) begin
              units_left_d = (bl < {8'd0, unit_limit_i}) ? bl[7:0] : unit_limit_i;
              if (units_left_d == 8'd0) begin
                emit        = 1'b1;
                emit_status = ST_NOEND;
              end else begin
                phase_d = PH_UNIT;
              end
            end else begin
              check_end = 1'b1;
            end
          end
          PH_UNIT: begin
            if (word_i.is_space) begin
              emit        = 1'b1;
              emit_status = ST_OK;
              emit_hash   = (hash_q == 8'd0) ? default_hash_i : hash_q;
            end else if (word_i.is_pct) begin
              phase_d   = PH_E1H;
              check_end = 1'b1;
            end else begin
              do_fold = 1'b1;
            end
          end
          PH_E1H: begin
            esc_d     = {word_i.nib[3:0], 4'd0};
            phase_d   = PH_E1L;
            check_end = 1'b1;
          end
          PH_E1L: begin
            if (esc_full[7:5] == UTF8_LEAD2) begin
              lead_d    = {esc_full[1:0], 6'd0};
              phase_d   = PH_SKIP;
              check_end = 1'b1;
            end else begin
              unit    = esc_full;
              do_fold = 1'b1;
            end
          end
          PH_SKIP: begin
            phase_d   = PH_E2H;
            check_end = 1'b1;
          end
          PH_E2H: begin
            esc_d     = {word_i.nib[3:0], 4'd0};
            phase_d   = PH_E2L;
            check_end = 1'b1;
          end
          PH_E2L: begin
            unit    = lead_q | {2'd0, esc_full[5:0]};
            do_fold = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        if (do_fold) begin
          hash_d       = prod + unit;
          units_left_d = units_new;
          phase_d      = PH_UNIT;
          if (units_new == 8'd0) begin
            emit        = 1'b1;
            emit_status = ST_NOEND;
          end else begin
            check_end = 1'b1;
          end
        end

        if (check_end && bl == 16'd0) begin
          emit        = 1'b1;
          emit_status = ST_NOEND;
        end
      end

      if (emit) begin
        phase_d = PH_IDLE;
      end
    end

    res_valid_d  = res_valid_q && !res_ready_i;
    res_status_d = res_status_q;
    res_hash_d   = res_hash_q;
    if (emit) begin
      res_valid_d  = 1'b1;
      res_status_d = emit_status;
      res_hash_d   = emit_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= '0;
      units_left_q <= '0;
      hash_q       <= '0;
      esc_q        <= '0;
      lead_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      units_left_q <= units_left_d;
      hash_q       <= hash_d;
      esc_q        <= esc_d;
      lead_q       <= lead_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_hash_q   <= res_hash_d;
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the GET request URI hash parser, driven by directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import hgup_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int ResetCycles   = 6;
  localparam int DrainCycles   = 16;
  localparam int HoldoffCycles = 400;
  localparam int MaxReports    = 10;

  typedef struct packed {
    status_e    status;
    logic [7:0] uri_hash;
  } uri_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // data_byte [7:0], segment_length [23:8]
  logic        s_axis_tuser  = 1'b0; // first_byte [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // status [1:0], uri_hash [9:2], zero [15:10]

  phase_e      pr_phase      = PH_IDLE;
  logic [15:0] pr_bytes_left = '0;
  logic [7:0]  pr_units_left = '0;
  logic [7:0]  pr_hash       = '0;
  logic [7:0]  pr_escape     = '0;
  logic [7:0]  pr_lead       = '0;
  logic [7:0]  pr_limit      = UNIT_LIMIT_RST;
  logic [7:0]  pr_default    = DEFAULT_HASH_RST;

  uri_result_t expected_hashes[$];
  logic [7:0]  req_bytes[$];
  int          failures         = 0;
  int          items_sent       = 0;
  int          snd_idle_pct     = 0;
  int          rcv_idle_pct     = 0;
  int          holdoff_requests = 0;

  http_get_uri_hash_parser dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  function automatic logic [7:0] hex_value(logic [7:0] t);
    if (t >= CH_0 && t <= CH_9) return t - CH_0;
    if (t >= CH_LA && t <= CH_LF) return t - CH_LA + 8'd10;
    return t + 8'd10 - CH_UA;
  endfunction

  function automatic void post_result(status_e st, logic [7:0] h);
    uri_result_t r;
    r.status   = st;
    r.uri_hash = h;
    expected_hashes.push_back(r);
    pr_phase = PH_IDLE;
  endfunction

  function automatic logic fold_unit(logic [7:0] ch);
    pr_hash       = pr_hash * HASH_MULT + ch;
    pr_units_left = pr_units_left - 8'd1;
    pr_phase      = PH_UNIT;
    return pr_units_left == 8'd0;
  endfunction

  function automatic void predict_word(logic [7:0] b, logic first, logic [15:0] seg_len);
    logic [7:0] v;
    if (first) begin
      if (seg_len <= MIN_GET_LEN) begin
        post_result(ST_NOGET, 8'd0);
        return;
      end
      pr_bytes_left = seg_len - 16'd1;
      pr_hash       = '0;
      pr_escape     = '0;
      pr_lead       = '0;
      pr_units_left = '0;
      if (b != CH_G) post_result(ST_NOGET, 8'd0);
      else pr_phase = PH_E;
      return;
    end
    if (pr_phase == PH_IDLE) return;
    pr_bytes_left = pr_bytes_left - 16'd1;
    case (pr_phase)
      PH_E: begin
        if (b != CH_E) post_result(ST_NOGET, 8'd0);
        else pr_phase = PH_T;
        return;
      end
      PH_T: begin
        if (b != CH_T) post_result(ST_NOGET, 8'd0);
        else pr_phase = PH_SLASH;
        return;
      end
      PH_SLASH: begin
        if (b == CH_SLASH) begin
          pr_units_left = (pr_bytes_left < {8'd0, pr_limit}) ? pr_bytes_left[7:0] : pr_limit;
          if (pr_units_left == 8'd0) begin
            post_result(ST_NOEND, 8'd0);
            return;
          end
          pr_phase = PH_UNIT;
        end
      end
      PH_UNIT: begin
        if (b == CH_SPACE) begin
          post_result(ST_OK, (pr_hash == 8'd0) ? pr_default : pr_hash);
          return;
        end
        if (b == CH_PCT) begin
          pr_phase = PH_E1H;
        end else if (fold_unit(b)) begin
          post_result(ST_NOEND, 8'd0);
          return;
        end
      end
      PH_E1H: begin
        v         = hex_value(b);
        pr_escape = {v[3:0], 4'h0};
        pr_phase  = PH_E1L;
      end
      PH_E1L: begin
        v = pr_escape | hex_value(b);
        if (v[7:5] == UTF8_LEAD2) begin
          pr_lead  = {v[1:0], 6'd0};
          pr_phase = PH_SKIP;
        end else if (fold_unit(v)) begin
          post_result(ST_NOEND, 8'd0);
          return;
        end
      end
      PH_SKIP: pr_phase = PH_E2H;
      PH_E2H: begin
        v         = hex_value(b);
        pr_escape = {v[3:0], 4'h0};
        pr_phase  = PH_E2L;
      end
      PH_E2L: begin
        v = pr_escape | hex_value(b);
        v = pr_lead | {2'b00, v[5:0]};
        if (fold_unit(v)) begin
          post_result(ST_NOEND, 8'd0);
          return;
        end
      end
      default: begin
        pr_phase = PH_IDLE;
        return;
      end
    endcase
    if (pr_bytes_left == 16'd0) post_result(ST_NOEND, 8'd0);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    string      digits = "0123456789abcdef";
    logic [7:0] c;
    c = digits[n];
    if (n > 4'd9 && $urandom_range(1) == 1) c = c - 8'h20;
    return c;
  endfunction

  function automatic void push_escape(logic [7:0] value);
    req_bytes.push_back(CH_PCT);
    req_bytes.push_back(hex_char(value[7:4]));
    req_bytes.push_back(hex_char(value[3:0]));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  task automatic send_word(logic [7:0] data, logic first, logic [15:0] seg_len);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {seg_len, data};
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(data, first, seg_len);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_request(logic [15:0] seg_len, int count);
    for (int i = 0; i < count; i++)
      send_word(req_bytes[i], i == 0, (i == 0) ? seg_len : 16'($urandom_range(65535)));
  endtask

  task automatic send_text(string s, logic [15:0] seg_len);
    req_bytes.delete();
    push_text(s);
    send_request(seg_len, req_bytes.size());
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_hashes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_config(logic [7:0] limit, logic [7:0] dflt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_UNIT_LIMIT;
    cfg_data_i <= limit;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_DEFAULT_HASH;
    cfg_data_i <= dflt;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pr_limit   = limit;
    pr_default = dflt;
  endtask

  // A request, mostly GET, with a random URI of plain bytes, escapes, UTF-8 escapes and malformed escapes.
  task automatic build_request();
    int         n_units;
    int         pick;
    logic [7:0] c;
    req_bytes.delete();
    push_text("GET");
    if ($urandom_range(9) == 0) req_bytes[$urandom_range(2)] = 8'($urandom_range(255));
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1) == 0) begin
        c = CH_SPACE;
      end else begin
        do c = 8'($urandom_range(255)); while (c == CH_SLASH);
      end
      req_bytes.push_back(c);
    end
    req_bytes.push_back(CH_SLASH);
    n_units = ($urandom_range(7) == 0) ? $urandom_range(9, 70) : $urandom_range(8);
    repeat (n_units) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_PCT);
        req_bytes.push_back(c);
      end else if (pick < 60) begin
        do c = 8'($urandom_range(255)); while (c == CH_PCT || c == CH_SPACE);
        req_bytes.push_back(c);
      end else if (pick < 78) begin
        push_escape(8'($urandom_range(255)));
      end else if (pick < 90) begin
        push_escape({3'b110, 5'($urandom_range(31))});
        push_escape(8'($urandom_range(255)));
        if ($urandom_range(4) == 0) req_bytes[req_bytes.size() - 3] = 8'($urandom_range(255));
      end else begin
        req_bytes.push_back(CH_PCT);
        req_bytes.push_back(8'($urandom_range(255)));
        req_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(6) != 0) begin
      req_bytes.push_back(CH_SPACE);
      repeat ($urandom_range(6)) req_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_rejections();
    send_word(CH_G, 1'b1, MIN_GET_LEN);
    send_word(8'hFF, 1'b0, 16'hFFFF);
    send_text("GX", 16'd200);
    send_text("GE", 16'hFFFF);
    send_text("X", 16'hFFFF);
  endtask

  task automatic test_uri_end_cases();
    send_text("GETa", 16'd4);
    send_text("GET/", 16'd4);
    send_text("GET/ ", 16'd5);
  endtask

  task automatic test_escapes();
    send_text("GET/%C3%A9%Gz", 16'd13);
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, logic [7:0] limit,
                                     logic [7:0] dflt, int n_items);
    int          start;
    int          reqs;
    int          count;
    int          pick;
    logic [15:0] seg_len;
    wait_idle();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    set_config(limit, dflt);
    start = items_sent;
    reqs  = 0;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          send_word(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
      end else if (pick < 12) begin
        send_word(8'($urandom_range(255)), 1'b1, 16'($urandom_range(65535)));
      end else begin
        build_request();
        count   = req_bytes.size();
        seg_len = 16'(count);
        pick    = $urandom_range(99);
        if (pick < 10) seg_len = 16'($urandom_range(count - 1));
        else if (pick < 20) seg_len = 16'($urandom_range(count + 1, 65535));
        else if (pick < 26) count = $urandom_range(1, count - 1);
        send_request(seg_len, count);
      end
      reqs++;
      if (reqs % 12 == 0) begin
        wait_idle();
        case ($urandom_range(3))
          0:       limit = 8'd1;
          1:       limit = 8'd255;
          2:       limit = 8'($urandom_range(2, 12));
          default: limit = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(3))
          0:       dflt = 8'd0;
          1:       dflt = 8'd255;
          default: dflt = 8'($urandom_range(255));
        endcase
        set_config(limit, dflt);
      end
    end
  endtask

  // Every word below is a short segment with a result of its own, so the block fills up.
  task automatic test_receiver_holdoff();
    wait_idle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    holdoff_requests++;
    repeat (40) send_word(8'($urandom_range(255)), 1'b1, 16'($urandom_range(3)));
  endtask

  initial begin
    int holdoffs_served;
    holdoffs_served = 0;
    forever begin
      @(negedge clk_i);
      if (holdoffs_served != holdoff_requests) begin
        holdoffs_served++;
        repeat (HoldoffCycles) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    uri_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hashes.size() == 0) begin
        if (failures < MaxReports)
          $display("unexpected result: status %0d hash %02h", m_axis_tdata[1:0],
                   m_axis_tdata[9:2]);
        failures++;
      end else begin
        want = expected_hashes.pop_front();
        if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[9:2] !== want.uri_hash ||
            m_axis_tdata[15:10] !== 6'd0) begin
          if (failures < MaxReports)
            $display("mismatch: expected status %0d hash %02h, got status %0d hash %02h pad %02h",
                     want.status, want.uri_hash, m_axis_tdata[1:0], m_axis_tdata[9:2],
                     m_axis_tdata[15:10]);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_rejections();
    test_uri_end_cases();
    test_escapes();
    test_random_traffic(16, 63, 8'd255, 8'd0, 480);
    test_random_traffic(63, 16, 8'd1, 8'd255, 480);
    test_random_traffic(0, 0, UNIT_LIMIT_RST, DEFAULT_HASH_RST, 480);
    test_receiver_holdoff();
    wait_idle();
    if (failures == 0 && expected_hashes.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hgup_pkg.sv
hw/rtl/hgup_front.sv
hw/rtl/hgup_fifo.sv
hw/rtl/hgup_back.sv
hw/rtl/http_get_uri_hash_parser.sv
tb/sv/testbench.sv
